[sv/jsu_pkg.sv]
package jsu_pkg;

    localparam int MAX_RUN = 6;

    // character codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_BS_CTL = 8'h08;
    localparam logic [7:0] CH_FF_CTL = 8'h0C;
    localparam logic [7:0] CH_LF_CTL = 8'h0A;

    localparam logic [15:0] SURR_HI_MIN = 16'hD800;
    localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
    localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
    localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'd0,
        MODE_STR    = 4'd1,
        MODE_ESC    = 4'd2,
        MODE_HEX    = 4'd3,
        MODE_HI_BS  = 4'd4,
        MODE_HI_U   = 4'd5,
        MODE_HI_HEX = 4'd6,
        MODE_DONE   = 4'd7,
        MODE_ERR    = 4'd8
    } t_mode;

    typedef enum logic [1:0] {
        ST_BUSY = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [1:0] parse_status;
        logic       run_end;
    } t_out_item;

    // decoded bytes of one input transaction
    typedef struct packed {
        logic [MAX_RUN-1:0][7:0] bytes;
        logic [2:0]              count;
        t_status                 status;
    } t_run;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      len;
    } t_enc;

    function automatic t_enc utf8_enc(input logic [20:0] cp);
        t_enc e;
        e = '0;
        if (cp <= 21'h7F) begin
            e.b[0] = cp[7:0];
            e.len  = 3'd1;
        end else if (cp <= 21'h7FF) begin
            e.b[0] = {3'b110, cp[10:6]};
            e.b[1] = {2'b10, cp[5:0]};
            e.len  = 3'd2;
        end else if (cp <= 21'hFFFF) begin
            e.b[0] = {4'b1110, cp[15:12]};
            e.b[1] = {2'b10, cp[11:6]};
            e.b[2] = {2'b10, cp[5:0]};
            e.len  = 3'd3;
        end else begin
            e.b[0] = {5'b11110, cp[20:18]};
            e.b[1] = {2'b10, cp[17:12]};
            e.b[2] = {2'b10, cp[11:6]};
            e.b[3] = {2'b10, cp[5:0]};
            e.len  = 3'd4;
        end
        return e;
    endfunction

    function automatic t_enc raw_enc(input logic [7:0] c);
        t_enc e;
        e      = '0;
        e.b[0] = c;
        e.len  = 3'd1;
        return e;
    endfunction

endpackage

[sv/jsu_decode.sv]
module jsu_decode
    import jsu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_take,
    input  t_in_item i_item,
    output t_run     o_run
);

    t_mode       r_mode, n_mode;
    logic [15:0] r_acc, n_acc;
    logic [1:0]  r_cnt, n_cnt;
    logic [15:0] r_held, n_held;

    logic [7:0]  c;
    logic        is_ws;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic        esc_ok;
    logic [7:0]  esc_byte;
    logic [15:0] acc_new;
    logic        emit_held;
    t_enc        held_e;
    t_enc        seg;
    t_mode       mode_pre;

    assign c = i_item.text_byte;
    assign is_ws = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    assign held_e = utf8_enc({5'd0, r_held});
    assign acc_new = {r_acc[11:0], hex_val};

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            hex_val = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            hex_val = 4'(c[2:0] + 3'd1) + 4'd8;
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        esc_ok   = 1'b1;
        esc_byte = c;
        case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: esc_byte = c;
            CH_LOW_B: esc_byte = CH_BS_CTL;
            CH_LOW_F: esc_byte = CH_FF_CTL;
            CH_LOW_N: esc_byte = CH_LF_CTL;
            CH_LOW_R: esc_byte = CH_CR;
            CH_LOW_T: esc_byte = CH_TAB;
            default:  esc_ok = 1'b0;
        endcase
    end

    always_comb begin
        n_mode    = r_mode;
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        n_held    = r_held;
        emit_held = 1'b0;
        seg       = '0;
        case (r_mode)
            MODE_IDLE: begin
                if (!is_ws) begin
                    n_mode = (c == CH_QUOTE) ? MODE_STR : MODE_ERR;
                end
            end
            MODE_STR, MODE_HI_BS: begin
                if (r_mode == MODE_HI_BS && c == CH_BSLASH) begin
                    n_mode = MODE_HI_U;
                end else begin
                    emit_held = (r_mode == MODE_HI_BS);
                    n_mode    = MODE_STR;
                    if (c == CH_QUOTE) begin
                        n_mode = MODE_DONE;
                    end else if (c == CH_BSLASH) begin
                        n_mode = MODE_ESC;
                    end else begin
                        seg = raw_enc(c);
                    end
                end
            end
            MODE_ESC, MODE_HI_U: begin
                if (c == CH_LOW_U) begin
                    n_mode = (r_mode == MODE_HI_U) ? MODE_HI_HEX : MODE_HEX;
                    n_acc  = '0;
                    n_cnt  = '0;
                end else begin
                    emit_held = (r_mode == MODE_HI_U);
                    if (esc_ok) begin
                        seg    = raw_enc(esc_byte);
                        n_mode = MODE_STR;
                    end else begin
                        n_mode = MODE_ERR;
                    end
                end
            end
            MODE_HEX, MODE_HI_HEX: begin
                if (!hex_ok) begin
                    emit_held = (r_mode == MODE_HI_HEX);
                    n_mode    = MODE_ERR;
                end else begin
                    n_acc = acc_new;
                    n_cnt = r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        n_cnt = '0;
                        if (r_mode == MODE_HI_HEX && acc_new >= SURR_LO_MIN
                                && acc_new <= SURR_LO_MAX) begin
                            // surrogate pair combines into one supplementary code point
                            seg    = utf8_enc(SUPP_BASE + {1'b0, r_held[9:0], acc_new[9:0]});
                            n_mode = MODE_STR;
                        end else begin
                            emit_held = (r_mode == MODE_HI_HEX);
                            if (acc_new >= SURR_HI_MIN && acc_new <= SURR_HI_MAX) begin
                                n_held = acc_new;
                                n_mode = MODE_HI_BS;
                            end else begin
                                seg    = utf8_enc({5'd0, acc_new});
                                n_mode = MODE_STR;
                            end
                        end
                    end
                end
            end
            MODE_DONE: n_mode = MODE_DONE;
            default:   n_mode = MODE_ERR;
        endcase

        mode_pre = n_mode;
        if (i_item.end_of_text) begin
            n_mode = MODE_IDLE;
            n_acc  = '0;
            n_cnt  = '0;
            n_held = '0;
        end
    end

    always_comb begin
        for (int k = 0; k < MAX_RUN; k++) begin
            if (emit_held) begin
                o_run.bytes[k] = (k < 3) ? held_e.b[2'(k)] : seg.b[2'(k - 3)];
            end else begin
                o_run.bytes[k] = (k < 4) ? seg.b[2'(k)] : 8'd0;
            end
        end
        o_run.count = (emit_held ? 3'd3 : 3'd0) + seg.len;
        if (mode_pre == MODE_DONE) begin
            o_run.status = ST_DONE;
        end else if (mode_pre == MODE_ERR || i_item.end_of_text) begin
            o_run.status = ST_ERR;
        end else begin
            o_run.status = ST_BUSY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_acc  <= '0;
            r_cnt  <= '0;
            r_held <= '0;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
            r_held <= n_held;
        end
    end

endmodule

[sv/json_string_unescape_utf8.sv]
// Streaming JSON string decoder: one text byte per input transaction, skipping leading
// whitespace, requiring an opening quote, then passing content bytes and decoding
// escapes (\uXXXX and surrogate pairs to UTF-8). Each input yields a run of 1 to 6
// output transactions; the last carries run_end and the status (in progress, complete,
// error). The decode of a byte is done in the cycle it is accepted and the run is held
// in a result register that drains one output transaction per cycle while i_out_ready is
// high; a new byte is accepted in the same cycle the last transaction of the previous
// run is taken, which gives one byte per cycle for runs of at most one transaction while
// the output stays ready.
module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_run       dec_run;
    logic       take;
    logic       r_busy;
    t_run       r_run;
    logic [2:0] r_idx;
    logic [2:0] r_last_idx;
    logic       at_last;

    assign at_last     = (r_idx == r_last_idx);
    assign o_out_valid = r_busy;
    assign o_in_ready  = !r_busy || (i_out_ready && at_last);
    assign take        = i_in_valid && o_in_ready;

    jsu_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (i_in_data),
        .o_run   (dec_run)
    );

    always_comb begin
        o_out_data.byte_valid   = (r_run.count != 3'd0);
        o_out_data.out_byte     = o_out_data.byte_valid ? r_run.bytes[r_idx] : 8'd0;
        o_out_data.run_end      = at_last;
        o_out_data.parse_status = at_last ? r_run.status : ST_BUSY;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (take) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy && i_out_ready) begin
            if (at_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    // payload of the held run
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_run      <= dec_run;
            r_last_idx <= (dec_run.count == 3'd0) ? 3'd0 : dec_run.count - 3'd1;
        end
    end

endmodule
